// ===== hdl/rmaw_pkg.sv =====
package rmaw_pkg;

	localparam int COUNT_BITS_DEF = 8;

	typedef enum logic [4:0] {
		ST_NONE          = 5'd0,
		ST_COMPLETE      = 5'd1,
		ST_CREATED       = 5'd2,
		ST_FENCE         = 5'd3,
		ST_FREED         = 5'd4,
		ST_LOCK          = 5'd5,
		ST_LOCKALL       = 5'd6,
		ST_LOCKANDALL    = 5'd7,
		ST_NPF           = 5'd8,
		ST_NPSF          = 5'd9,
		ST_NSF           = 5'd10,
		ST_POST          = 5'd11,
		ST_POSTSTART     = 5'd12,
		ST_RCFENCE       = 5'd13,
		ST_RCGATS        = 5'd14,
		ST_RCGATSPS      = 5'd15,
		ST_RCLOCK        = 5'd16,
		ST_RCLOCKALL     = 5'd17,
		ST_RCLOCKANDALL  = 5'd18,
		ST_START         = 5'd19,
		ST_TESTWAIT      = 5'd20
	} wstate_t;

	typedef enum logic [4:0] {
		EV_NEUTRAL   = 5'd0,
		EV_COMPLETE  = 5'd1,
		EV_CREATED   = 5'd2,
		EV_FENCE     = 5'd3,
		EV_FLUSH     = 5'd4,
		EV_FREED     = 5'd5,
		EV_LOCK      = 5'd6,
		EV_LOCKALL   = 5'd7,
		EV_NPF       = 5'd8,
		EV_NPSF      = 5'd9,
		EV_NSF       = 5'd10,
		EV_POST      = 5'd11,
		EV_RC        = 5'd12,
		EV_REQ_RC    = 5'd13,
		EV_START     = 5'd14,
		EV_SYNC      = 5'd15,
		EV_TESTWAIT  = 5'd16,
		EV_UNLOCK    = 5'd17,
		EV_UNLOCKALL = 5'd18
	} event_t;

	typedef struct packed {
		logic [4:0] event_req;
	} evt_t;

	typedef struct packed {
		logic       accepted;
		logic       final_state;
		logic [4:0] window_state;
	} res_t;

endpackage

// ===== hdl/rmaw_stream_if.sv =====
interface rmaw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/rma_window_sync_checker.sv =====
// channel | dir | payload                                   | accepted when
// evt     | in  | event_req[4:0]                            | evt.valid && evt.ready
// res     | out | accepted, final_state, window_state[4:0] | res.valid && res.ready
//
// One event per cycle while no result is stalled; each result appears in the
// cycle after its event is taken, from the single state/counter update loop.
// Reset puts the window in state None with a zero lock count, output empty.
// evt.ready stays high while the output register is empty or being drained,
// so a stalled result blocks only the next event.
module rma_window_sync_checker #(
	parameter int COUNT_BITS = rmaw_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmaw_stream_if.sink   evt,
	rmaw_stream_if.source res
);

	localparam logic [COUNT_BITS-1:0] DEPTH_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] DEPTH_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] DEPTH_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	rmaw_pkg::wstate_t     state_q, st_d;
	logic [COUNT_BITS-1:0] depth_q, dep_d;
	logic                  sf_q, sf_d;
	logic                  ok;
	logic                  out_valid_q;
	rmaw_pkg::res_t        res_q;
	rmaw_pkg::event_t      ev;
	logic                  take;

	function automatic logic fencey(input rmaw_pkg::wstate_t s);
		return s == rmaw_pkg::ST_FENCE || s == rmaw_pkg::ST_NPF ||
			s == rmaw_pkg::ST_NPSF || s == rmaw_pkg::ST_NSF;
	endfunction

	function automatic logic opener(input rmaw_pkg::wstate_t s, input logic sf);
		return s == rmaw_pkg::ST_COMPLETE || s == rmaw_pkg::ST_CREATED ||
			s == rmaw_pkg::ST_TESTWAIT || (fencey(s) && sf);
	endfunction

	function automatic logic fence_from(input rmaw_pkg::wstate_t s, input logic allow_created,
		input logic allow_rcfence);
		return s == rmaw_pkg::ST_COMPLETE || s == rmaw_pkg::ST_TESTWAIT || fencey(s) ||
			(allow_created && s == rmaw_pkg::ST_CREATED) ||
			(allow_rcfence && s == rmaw_pkg::ST_RCFENCE);
	endfunction

	assign ev   = rmaw_pkg::event_t'(evt.payload.event_req);
	assign take = evt.valid && evt.ready;

	always_comb begin
		st_d  = state_q;
		dep_d = depth_q;
		sf_d  = sf_q;
		ok    = 1'b0;
		unique case (ev)
			rmaw_pkg::EV_NEUTRAL: begin
				ok = 1'b1;
			end
			rmaw_pkg::EV_COMPLETE: begin
				if (state_q == rmaw_pkg::ST_POSTSTART || state_q == rmaw_pkg::ST_RCGATSPS) begin
					st_d = rmaw_pkg::ST_POST;
					ok   = 1'b1;
				end else if (state_q == rmaw_pkg::ST_START || state_q == rmaw_pkg::ST_RCGATS) begin
					st_d = rmaw_pkg::ST_COMPLETE;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_CREATED: begin
				if (state_q == rmaw_pkg::ST_NONE) begin
					st_d = rmaw_pkg::ST_CREATED;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_FENCE: begin
				if (fence_from(state_q, 1'b1, 1'b1)) begin
					st_d = rmaw_pkg::ST_FENCE;
					sf_d = sf_q | fencey(state_q);
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_NPF: begin
				if (fence_from(state_q, 1'b1, 1'b0)) begin
					st_d = rmaw_pkg::ST_NPF;
					sf_d = sf_q | fencey(state_q);
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_NPSF: begin
				if (fence_from(state_q, 1'b1, 1'b0)) begin
					st_d = rmaw_pkg::ST_NPSF;
					sf_d = sf_q | fencey(state_q);
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_NSF: begin
				if (fence_from(state_q, 1'b0, 1'b1)) begin
					st_d = rmaw_pkg::ST_NSF;
					sf_d = sf_q | fencey(state_q);
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_FLUSH, rmaw_pkg::EV_SYNC: begin
				ok = state_q == rmaw_pkg::ST_LOCK || state_q == rmaw_pkg::ST_LOCKALL ||
					state_q == rmaw_pkg::ST_LOCKANDALL || state_q == rmaw_pkg::ST_RCLOCK ||
					state_q == rmaw_pkg::ST_RCLOCKALL;
			end
			rmaw_pkg::EV_FREED: begin
				if (state_q == rmaw_pkg::ST_COMPLETE || state_q == rmaw_pkg::ST_CREATED ||
					state_q == rmaw_pkg::ST_TESTWAIT || fencey(state_q)) begin
					st_d = rmaw_pkg::ST_FREED;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_LOCK: begin
				if ((opener(state_q, sf_q) || state_q == rmaw_pkg::ST_LOCK ||
					state_q == rmaw_pkg::ST_LOCKALL || state_q == rmaw_pkg::ST_LOCKANDALL ||
					state_q == rmaw_pkg::ST_RCLOCK) && depth_q != DEPTH_MAX) begin
					dep_d = depth_q + DEPTH_ONE;
					st_d  = (state_q == rmaw_pkg::ST_LOCKALL) ? rmaw_pkg::ST_LOCKANDALL
						: rmaw_pkg::ST_LOCK;
					ok    = 1'b1;
				end
			end
			rmaw_pkg::EV_LOCKALL: begin
				if (opener(state_q, sf_q) || state_q == rmaw_pkg::ST_RCLOCK) begin
					st_d = rmaw_pkg::ST_LOCKALL;
					ok   = 1'b1;
				end else if (state_q == rmaw_pkg::ST_LOCK) begin
					st_d = rmaw_pkg::ST_LOCKANDALL;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_POST: begin
				if (opener(state_q, sf_q)) begin
					st_d = rmaw_pkg::ST_POST;
					ok   = 1'b1;
				end else if (state_q == rmaw_pkg::ST_START) begin
					st_d = rmaw_pkg::ST_POSTSTART;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_RC, rmaw_pkg::EV_REQ_RC: begin
				ok = 1'b1;
				if (ev == rmaw_pkg::EV_RC && (state_q == rmaw_pkg::ST_FENCE ||
					state_q == rmaw_pkg::ST_NPF || state_q == rmaw_pkg::ST_RCFENCE)) begin
					st_d = rmaw_pkg::ST_RCFENCE;
				end else if (ev == rmaw_pkg::EV_RC && (state_q == rmaw_pkg::ST_POSTSTART ||
					state_q == rmaw_pkg::ST_RCGATSPS)) begin
					st_d = rmaw_pkg::ST_RCGATSPS;
				end else if (ev == rmaw_pkg::EV_RC && (state_q == rmaw_pkg::ST_START ||
					state_q == rmaw_pkg::ST_RCGATS)) begin
					st_d = rmaw_pkg::ST_RCGATS;
				end else if (state_q == rmaw_pkg::ST_LOCK || state_q == rmaw_pkg::ST_RCLOCK) begin
					st_d = rmaw_pkg::ST_RCLOCK;
				end else if (state_q == rmaw_pkg::ST_LOCKALL ||
					state_q == rmaw_pkg::ST_RCLOCKALL) begin
					st_d = rmaw_pkg::ST_RCLOCKALL;
				end else if (state_q == rmaw_pkg::ST_LOCKANDALL ||
					state_q == rmaw_pkg::ST_RCLOCKANDALL) begin
					st_d = rmaw_pkg::ST_RCLOCKANDALL;
				end else begin
					ok = 1'b0;
				end
			end
			rmaw_pkg::EV_START: begin
				if (opener(state_q, sf_q)) begin
					st_d = rmaw_pkg::ST_START;
					ok   = 1'b1;
				end else if (state_q == rmaw_pkg::ST_POST) begin
					st_d = rmaw_pkg::ST_POSTSTART;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_TESTWAIT: begin
				if (state_q == rmaw_pkg::ST_POST) begin
					st_d = rmaw_pkg::ST_TESTWAIT;
					ok   = 1'b1;
				end else if (state_q == rmaw_pkg::ST_POSTSTART ||
					state_q == rmaw_pkg::ST_RCGATSPS) begin
					st_d = rmaw_pkg::ST_START;
					ok   = 1'b1;
				end
			end
			rmaw_pkg::EV_UNLOCK: begin
				if ((state_q == rmaw_pkg::ST_LOCK || state_q == rmaw_pkg::ST_LOCKANDALL ||
					state_q == rmaw_pkg::ST_RCLOCK || state_q == rmaw_pkg::ST_RCLOCKANDALL) &&
					depth_q != DEPTH_MIN) begin
					// count moves even when it goes negative and the item is rejected
					dep_d = depth_q - DEPTH_ONE;
					if (!dep_d[COUNT_BITS-1]) begin
						ok = 1'b1;
						if (dep_d == '0) begin
							if (state_q == rmaw_pkg::ST_LOCKANDALL) begin
								st_d = rmaw_pkg::ST_LOCKALL;
							end else if (state_q == rmaw_pkg::ST_RCLOCKANDALL) begin
								st_d = rmaw_pkg::ST_RCLOCKALL;
							end else begin
								st_d = rmaw_pkg::ST_CREATED;
							end
						end
					end
				end
			end
			rmaw_pkg::EV_UNLOCKALL: begin
				ok = 1'b1;
				if (state_q == rmaw_pkg::ST_LOCKANDALL) begin
					st_d = rmaw_pkg::ST_LOCK;
				end else if (state_q == rmaw_pkg::ST_RCLOCKANDALL) begin
					st_d = rmaw_pkg::ST_RCLOCK;
				end else if (state_q == rmaw_pkg::ST_LOCKALL ||
					state_q == rmaw_pkg::ST_RCLOCKALL) begin
					st_d = rmaw_pkg::ST_CREATED;
				end else begin
					ok = 1'b0;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmaw_pkg::ST_NONE;
			depth_q     <= '0;
			sf_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q     <= st_d;
				depth_q     <= dep_d;
				sf_q        <= sf_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.accepted     <= ok;
			res_q.final_state  <= (st_d == rmaw_pkg::ST_FREED) && (dep_d == '0);
			res_q.window_state <= st_d;
		end
	end

	assign evt.ready   = !out_valid_q || res.ready;
	assign res.valid   = out_valid_q;
	assign res.payload = res_q;

endmodule

// ===== hdl/rmaw_checker.sv =====
module rmaw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_accepted,
	input logic       out_final_state,
	input logic [4:0] out_window_state
);

	logic in_take;

	assign in_take = in_valid && in_ready;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
		$stable(out_final_state) && $stable(out_window_state))
		else $error("result changed while stalled");

	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> out_valid)
		else $error("accepted item produced no result");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(in_take) |-> $past(out_valid) && !$past(out_ready))
		else $error("result without an item");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_take ##1 in_take |=> out_accepted || out_window_state == $past(out_window_state))
		else $error("rejected item moved the window state");

	a_final_freed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_final_state |-> out_window_state == rmaw_pkg::ST_FREED)
		else $error("final flag outside freed state");

endmodule

bind rma_window_sync_checker rmaw_checker u_rmaw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (evt.valid),
	.in_ready         (evt.ready),
	.out_valid        (res.valid),
	.out_ready        (res.ready),
	.out_accepted     (res.payload.accepted),
	.out_final_state  (res.payload.final_state),
	.out_window_state (res.payload.window_state)
);

// ===== bench/rma_window_sync_checker_tb.sv =====
module rma_window_sync_checker_tb;

	localparam int DEPTH_W = rmaw_pkg::COUNT_BITS_DEF;
	localparam longint DEPTH_MAX = (longint'(1) << (DEPTH_W - 1)) - 1;
	localparam longint DEPTH_MIN = -(longint'(1) << (DEPTH_W - 1));
	localparam int RANDOM_EVENTS = 600;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [4:0]     code;
		logic           known;
		rmaw_pkg::res_t want;
	} dir_row_t;

	// known rows carry the result typed in; every row goes through the predictor
	localparam dir_row_t DIRECTED [27] = '{
		'{rmaw_pkg::EV_NEUTRAL,   1'b1, '{1'b1, 1'b0, rmaw_pkg::ST_NONE}},
		'{5'd31,                  1'b1, '{1'b0, 1'b0, rmaw_pkg::ST_NONE}},
		'{rmaw_pkg::EV_CREATED,   1'b1, '{1'b1, 1'b0, rmaw_pkg::ST_CREATED}},
		'{rmaw_pkg::EV_CREATED,   1'b1, '{1'b0, 1'b0, rmaw_pkg::ST_CREATED}},
		'{rmaw_pkg::EV_FENCE,     1'b0, '0},
		'{rmaw_pkg::EV_NPF,       1'b0, '0},
		'{rmaw_pkg::EV_POST,      1'b0, '0},
		'{rmaw_pkg::EV_START,     1'b0, '0},
		'{rmaw_pkg::EV_RC,        1'b0, '0},
		'{rmaw_pkg::EV_TESTWAIT,  1'b0, '0},
		'{rmaw_pkg::EV_COMPLETE,  1'b0, '0},
		'{rmaw_pkg::EV_NSF,       1'b0, '0},
		'{rmaw_pkg::EV_NPSF,      1'b0, '0},
		'{rmaw_pkg::EV_LOCK,      1'b0, '0},
		'{rmaw_pkg::EV_LOCK,      1'b0, '0},
		'{rmaw_pkg::EV_LOCK,      1'b0, '0},
		'{rmaw_pkg::EV_LOCK,      1'b0, '0},
		'{rmaw_pkg::EV_LOCKALL,   1'b0, '0},
		'{rmaw_pkg::EV_REQ_RC,    1'b0, '0},
		'{rmaw_pkg::EV_UNLOCKALL, 1'b0, '0},
		'{rmaw_pkg::EV_SYNC,      1'b0, '0},
		'{rmaw_pkg::EV_FLUSH,     1'b0, '0},
		'{rmaw_pkg::EV_UNLOCK,    1'b0, '0},
		'{rmaw_pkg::EV_UNLOCK,    1'b0, '0},
		'{rmaw_pkg::EV_UNLOCK,    1'b0, '0},
		'{rmaw_pkg::EV_UNLOCK,    1'b0, '0},
		'{5'd19,                  1'b1, '{1'b0, 1'b0, rmaw_pkg::ST_CREATED}}
	};

	logic clk;
	logic arst_n;

	rmaw_stream_if #(.payload_t(rmaw_pkg::evt_t)) evt_if ();
	rmaw_stream_if #(.payload_t(rmaw_pkg::res_t)) res_if ();

	rma_window_sync_checker #(
		.COUNT_BITS(DEPTH_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_if),
		.res(res_if)
	);

	rmaw_pkg::wstate_t win_st;
	longint            lock_cnt;
	bit                fence2;

	rmaw_pkg::res_t exp_q [$];
	int             errs;
	int             snd_idle;
	int             rcv_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_fence_st(rmaw_pkg::wstate_t s);
		return s == rmaw_pkg::ST_FENCE || s == rmaw_pkg::ST_NPF ||
			s == rmaw_pkg::ST_NPSF || s == rmaw_pkg::ST_NSF;
	endfunction

	function automatic bit can_open(rmaw_pkg::wstate_t s);
		return s == rmaw_pkg::ST_COMPLETE || s == rmaw_pkg::ST_CREATED ||
			s == rmaw_pkg::ST_TESTWAIT || (is_fence_st(s) && fence2);
	endfunction

	function automatic bit fence_move(rmaw_pkg::wstate_t s, bit w_cr, bit w_rcf,
		rmaw_pkg::wstate_t tgt);
		if (s == rmaw_pkg::ST_COMPLETE || s == rmaw_pkg::ST_TESTWAIT || is_fence_st(s) ||
				(w_cr && s == rmaw_pkg::ST_CREATED) ||
				(w_rcf && s == rmaw_pkg::ST_RCFENCE)) begin
			if (is_fence_st(s))
				fence2 = 1'b1;
			win_st = tgt;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit lock_kin(rmaw_pkg::wstate_t s, output rmaw_pkg::wstate_t nx);
		nx = s;
		if (s == rmaw_pkg::ST_LOCK || s == rmaw_pkg::ST_RCLOCK) begin
			nx = rmaw_pkg::ST_RCLOCK;
			return 1'b1;
		end
		if (s == rmaw_pkg::ST_LOCKALL || s == rmaw_pkg::ST_RCLOCKALL) begin
			nx = rmaw_pkg::ST_RCLOCKALL;
			return 1'b1;
		end
		if (s == rmaw_pkg::ST_LOCKANDALL || s == rmaw_pkg::ST_RCLOCKANDALL) begin
			nx = rmaw_pkg::ST_RCLOCKANDALL;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit apply_event(logic [4:0] code);
		rmaw_pkg::wstate_t s;
		rmaw_pkg::wstate_t nx;
		bit ok;
		s = win_st;
		ok = 1'b0;
		case (code)
			rmaw_pkg::EV_NEUTRAL: ok = 1'b1;
			rmaw_pkg::EV_COMPLETE: begin
				ok = 1'b1;
				if (s == rmaw_pkg::ST_POSTSTART || s == rmaw_pkg::ST_RCGATSPS)
					win_st = rmaw_pkg::ST_POST;
				else if (s == rmaw_pkg::ST_START || s == rmaw_pkg::ST_RCGATS)
					win_st = rmaw_pkg::ST_COMPLETE;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_CREATED: begin
				if (s == rmaw_pkg::ST_NONE) begin
					win_st = rmaw_pkg::ST_CREATED;
					ok = 1'b1;
				end
			end
			rmaw_pkg::EV_FENCE: ok = fence_move(s, 1'b1, 1'b1, rmaw_pkg::ST_FENCE);
			rmaw_pkg::EV_FLUSH, rmaw_pkg::EV_SYNC: begin
				ok = s == rmaw_pkg::ST_LOCK || s == rmaw_pkg::ST_LOCKALL ||
					s == rmaw_pkg::ST_LOCKANDALL || s == rmaw_pkg::ST_RCLOCK ||
					s == rmaw_pkg::ST_RCLOCKALL;
			end
			rmaw_pkg::EV_FREED: begin
				if (s == rmaw_pkg::ST_COMPLETE || s == rmaw_pkg::ST_CREATED ||
						s == rmaw_pkg::ST_TESTWAIT || is_fence_st(s)) begin
					win_st = rmaw_pkg::ST_FREED;
					ok = 1'b1;
				end
			end
			rmaw_pkg::EV_LOCK: begin
				if ((can_open(s) || s == rmaw_pkg::ST_LOCK || s == rmaw_pkg::ST_LOCKALL ||
						s == rmaw_pkg::ST_LOCKANDALL || s == rmaw_pkg::ST_RCLOCK) &&
						lock_cnt < DEPTH_MAX) begin
					lock_cnt++;
					win_st = (s == rmaw_pkg::ST_LOCKALL) ? rmaw_pkg::ST_LOCKANDALL
						: rmaw_pkg::ST_LOCK;
					ok = 1'b1;
				end
			end
			rmaw_pkg::EV_LOCKALL: begin
				ok = 1'b1;
				if (can_open(s) || s == rmaw_pkg::ST_RCLOCK)
					win_st = rmaw_pkg::ST_LOCKALL;
				else if (s == rmaw_pkg::ST_LOCK)
					win_st = rmaw_pkg::ST_LOCKANDALL;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_NPF: ok = fence_move(s, 1'b1, 1'b0, rmaw_pkg::ST_NPF);
			rmaw_pkg::EV_NPSF: ok = fence_move(s, 1'b1, 1'b0, rmaw_pkg::ST_NPSF);
			rmaw_pkg::EV_NSF: ok = fence_move(s, 1'b0, 1'b1, rmaw_pkg::ST_NSF);
			rmaw_pkg::EV_POST: begin
				ok = 1'b1;
				if (can_open(s))
					win_st = rmaw_pkg::ST_POST;
				else if (s == rmaw_pkg::ST_START)
					win_st = rmaw_pkg::ST_POSTSTART;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_RC: begin
				ok = 1'b1;
				if (s == rmaw_pkg::ST_FENCE || s == rmaw_pkg::ST_NPF ||
						s == rmaw_pkg::ST_RCFENCE)
					win_st = rmaw_pkg::ST_RCFENCE;
				else if (s == rmaw_pkg::ST_POSTSTART || s == rmaw_pkg::ST_RCGATSPS)
					win_st = rmaw_pkg::ST_RCGATSPS;
				else if (s == rmaw_pkg::ST_START || s == rmaw_pkg::ST_RCGATS)
					win_st = rmaw_pkg::ST_RCGATS;
				else if (lock_kin(s, nx))
					win_st = nx;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_REQ_RC: begin
				if (lock_kin(s, nx)) begin
					win_st = nx;
					ok = 1'b1;
				end
			end
			rmaw_pkg::EV_START: begin
				ok = 1'b1;
				if (can_open(s))
					win_st = rmaw_pkg::ST_START;
				else if (s == rmaw_pkg::ST_POST)
					win_st = rmaw_pkg::ST_POSTSTART;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_TESTWAIT: begin
				ok = 1'b1;
				if (s == rmaw_pkg::ST_POST)
					win_st = rmaw_pkg::ST_TESTWAIT;
				else if (s == rmaw_pkg::ST_POSTSTART || s == rmaw_pkg::ST_RCGATSPS)
					win_st = rmaw_pkg::ST_START;
				else
					ok = 1'b0;
			end
			rmaw_pkg::EV_UNLOCK: begin
				if ((s == rmaw_pkg::ST_LOCK || s == rmaw_pkg::ST_LOCKANDALL ||
						s == rmaw_pkg::ST_RCLOCK || s == rmaw_pkg::ST_RCLOCKANDALL) &&
						lock_cnt > DEPTH_MIN) begin
					// count moves even when it goes negative and the item is rejected
					lock_cnt--;
					if (lock_cnt >= 0) begin
						ok = 1'b1;
						if (lock_cnt == 0) begin
							if (s == rmaw_pkg::ST_LOCKANDALL)
								win_st = rmaw_pkg::ST_LOCKALL;
							else if (s == rmaw_pkg::ST_RCLOCKANDALL)
								win_st = rmaw_pkg::ST_RCLOCKALL;
							else
								win_st = rmaw_pkg::ST_CREATED;
						end
					end
				end
			end
			rmaw_pkg::EV_UNLOCKALL: begin
				ok = 1'b1;
				if (s == rmaw_pkg::ST_LOCKANDALL)
					win_st = rmaw_pkg::ST_LOCK;
				else if (s == rmaw_pkg::ST_RCLOCKANDALL)
					win_st = rmaw_pkg::ST_RCLOCK;
				else if (s == rmaw_pkg::ST_LOCKALL || s == rmaw_pkg::ST_RCLOCKALL)
					win_st = rmaw_pkg::ST_CREATED;
				else
					ok = 1'b0;
			end
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic rmaw_pkg::res_t predict_window(logic [4:0] code);
		rmaw_pkg::res_t r;
		r.accepted = apply_event(code);
		r.final_state = (win_st == rmaw_pkg::ST_FREED && lock_cnt == 0);
		r.window_state = win_st;
		return r;
	endfunction

	function automatic bit would_accept(logic [4:0] code);
		rmaw_pkg::wstate_t s_sv;
		longint            c_sv;
		bit                f_sv;
		bit                ok;
		s_sv = win_st;
		c_sv = lock_cnt;
		f_sv = fence2;
		ok = apply_event(code);
		win_st = s_sv;
		lock_cnt = c_sv;
		fence2 = f_sv;
		return ok;
	endfunction

	// a permitted event other than Freed, neutral if none is found quickly
	function automatic logic [4:0] pick_legal();
		logic [4:0] c;
		for (int k = 0; k < 12; k++) begin
			c = 5'($urandom_range(1, 18));
			if (c != rmaw_pkg::EV_FREED && would_accept(c))
				return c;
		end
		return rmaw_pkg::EV_NEUTRAL;
	endfunction

	task automatic push_event(input logic [4:0] code, input logic known,
		input rmaw_pkg::res_t want);
		rmaw_pkg::res_t pred;
		if ($urandom_range(0, 99) < snd_idle) begin
			evt_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < snd_idle)
				@(posedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.payload.event_req <= code;
		do
			@(posedge clk);
		while (!evt_if.ready);
		pred = predict_window(code);
		exp_q.push_back(known ? want : pred);
	endtask

	task automatic hold_until_drained();
		evt_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (exp_q.size() != 0);
	endtask

	// result side: check every accepted item, then pick ready for the next cycle
	initial begin
		rmaw_pkg::res_t want;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				if (exp_q.size() == 0) begin
					$display("%0t: result with nothing expected: acc=%0b fin=%0b st=%0d",
						$time, res_if.payload.accepted, res_if.payload.final_state,
						res_if.payload.window_state);
					errs++;
				end else begin
					want = exp_q.pop_front();
					if (res_if.payload.accepted !== want.accepted) begin
						$display("%0t: accepted expected %0b actual %0b", $time,
							want.accepted, res_if.payload.accepted);
						errs++;
					end
					if (res_if.payload.final_state !== want.final_state) begin
						$display("%0t: final_state expected %0b actual %0b", $time,
							want.final_state, res_if.payload.final_state);
						errs++;
					end
					if (res_if.payload.window_state !== want.window_state) begin
						$display("%0t: window_state expected %0d actual %0d", $time,
							want.window_state, res_if.payload.window_state);
						errs++;
					end
				end
			end
			res_if.ready <= arst_n && ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("rma_window_sync_checker test failed");
		$finish;
	end

	initial begin
		logic [4:0] code;
		int n;
		errs = 0;
		win_st = rmaw_pkg::ST_NONE;
		lock_cnt = 0;
		fence2 = 1'b0;
		snd_idle = 31;
		rcv_idle = 68;
		arst_n <= 1'b0;
		evt_if.valid <= 1'b0;
		evt_if.payload <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			push_event(DIRECTED[i].code, DIRECTED[i].known, DIRECTED[i].want);

		for (int k = 0; k < RANDOM_EVENTS; k++) begin
			if (k == RANDOM_EVENTS / 3) begin
				hold_until_drained();
				snd_idle = 68;
				rcv_idle = 31;
			end else if (k == 2 * RANDOM_EVENTS / 3) begin
				hold_until_drained();
				snd_idle = 0;
				rcv_idle = 0;
			end
			if ($urandom_range(0, 99) < 80) begin
				code = pick_legal();
			end else begin
				code = 5'($urandom_range(0, 31));
				// Freed ends the window for good; keep it for the tail
				if (code == rmaw_pkg::EV_FREED && would_accept(code))
					code = rmaw_pkg::EV_FLUSH;
			end
			push_event(code, 1'b0, '0);
		end

		// wind the locks down and free the window, then poke the dead window
		n = 0;
		while (win_st != rmaw_pkg::ST_FREED && n < 400) begin
			if (would_accept(rmaw_pkg::EV_UNLOCK))
				code = rmaw_pkg::EV_UNLOCK;
			else if (would_accept(rmaw_pkg::EV_UNLOCKALL))
				code = rmaw_pkg::EV_UNLOCKALL;
			else if ((lock_cnt == 0 || n > 150) && would_accept(rmaw_pkg::EV_FREED))
				code = rmaw_pkg::EV_FREED;
			else
				code = pick_legal();
			push_event(code, 1'b0, '0);
			n++;
		end
		for (int k = 0; k < 8; k++)
			push_event(5'($urandom_range(0, 31)), 1'b0, '0);

		evt_if.valid <= 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errs == 0 && exp_q.size() == 0)
			$display("rma_window_sync_checker test passed");
		else
			$display("rma_window_sync_checker test failed");
		$finish;
	end

endmodule
